[src/gefd_pkg.sv]
// Package for the geared encoder feedback decoder.
// Holds the item types, the queue entry, the back-end state enum and fixed constants.
// No dependencies.
package gefd_pkg;

    // Field widths fixed by the frame format
    localparam int ANGLE_W = 13;
    localparam int SPEED_W = 16;
    localparam int RATIO_W = 8;

    // Encoder full scale and half scale
    localparam logic [ANGLE_W-1:0] ENCODER_MAX = 13'd8191;
    localparam logic [ANGLE_W-1:0] HALF_SPAN   = ENCODER_MAX / 2;

    // Serial divider: one dividend lane per quotient, all sharing the ratio
    localparam int DIV_W      = 16;
    localparam int DIV_LANES  = 4;
    localparam int LANE_SPEED = 0;
    localparam int LANE_ANGLE = 1;
    localparam int LANE_HALF  = 2;
    localparam int LANE_SPAN  = 3;

    // Input item
    typedef struct packed {
        logic [ANGLE_W-1:0]        raw_angle;
        logic signed [SPEED_W-1:0] raw_speed;
    } frame_t;

    // Result item
    typedef struct packed {
        logic signed [SPEED_W-1:0] rotor_speed;
        logic signed [SPEED_W-1:0] shaft_speed;
        logic [ANGLE_W-1:0]        reduced_angle;
        logic [RATIO_W-1:0]        turn_index;
        logic [ANGLE_W-1:0]        shaft_angle;
    } result_t;

    // Classified command waiting between front and back
    typedef struct packed {
        logic [ANGLE_W-1:0]        raw_angle;
        logic signed [SPEED_W-1:0] raw_speed;
        logic                      speed_neg;
        logic [SPEED_W-1:0]        speed_mag;
        logic [RATIO_W-1:0]        ratio;
    } cmd_t;

    // Dividend / quotient bundle for the divider lanes
    typedef logic [DIV_LANES-1:0][DIV_W-1:0] div_word_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_TRACK,
        ST_SCALE,
        ST_OUT
    } back_state_t;

endpackage

[src/gefd_front.sv]
// Front end: ratio register, item intake, classification and the command queue.
// Depends on gefd_pkg.
module gefd_front #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  gefd_pkg::frame_t             frame,
    input  logic                         cfg_en,
    input  logic [gefd_pkg::RATIO_W-1:0] cfg_data,
    input  logic                         q_pop,
    output logic                         q_empty,
    output gefd_pkg::cmd_t               q_head
);
    import gefd_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [RATIO_W-1:0] gear_ratio_reg;
    cmd_t               queue_mem [QUEUE_DEPTH];
    logic [PW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               wr_en, rd_en;
    cmd_t               cmd_in;

    // Ratio register; zero is handled when the item is classified
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gear_ratio_reg <= RATIO_W'(1);
        else if (cfg_en)
            gear_ratio_reg <= cfg_data;
    end

    // Classify: speed sign and magnitude, effective ratio
    always_comb
    begin
        cmd_in.raw_angle = frame.raw_angle;
        cmd_in.raw_speed = frame.raw_speed;
        cmd_in.speed_neg = frame.raw_speed[SPEED_W-1];
        cmd_in.speed_mag = frame.raw_speed[SPEED_W-1] ?
                           (SPEED_W'(0) - frame.raw_speed) : frame.raw_speed;
        cmd_in.ratio     = (gear_ratio_reg == '0) ? RATIO_W'(1) : gear_ratio_reg;
    end

    // Queue control
    assign full    = (count_reg == CW'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign wr_en   = push && !full;
    assign rd_en   = q_pop && !q_empty;
    assign q_head  = queue_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (wr_en && !rd_en)
            count_next = count_reg + CW'(1);
        else if (rd_en && !wr_en)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            queue_mem[wr_ptr_reg] <= cmd_in;
    end

endmodule

[src/gefd_div.sv]
// Shared serial divider: restoring division, one quotient bit per cycle,
// several dividend lanes against one 8-bit divisor. Depends on gefd_pkg.
module gefd_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  gefd_pkg::div_word_t          dividend,
    input  logic [gefd_pkg::RATIO_W-1:0] divisor,
    output logic                         done,
    output gefd_pkg::div_word_t          quotient
);
    import gefd_pkg::*;

    localparam int SW = $clog2(DIV_W);

    logic [RATIO_W-1:0]                 divisor_reg;
    logic [DIV_LANES-1:0][RATIO_W-1:0]  rem_reg, rem_next;
    div_word_t                          quo_reg, quo_next;
    logic [SW-1:0]                      step_reg;
    logic                               busy_reg;
    logic                               done_reg;

    // One restoring step per lane
    always_comb
    begin
        for (int l = 0; l < DIV_LANES; l++)
        begin
            logic [RATIO_W:0] shifted;
            logic             ge;
            shifted     = {rem_reg[l], quo_reg[l][DIV_W-1]};
            ge          = (shifted >= {1'b0, divisor_reg});
            rem_next[l] = ge ? RATIO_W'(shifted - {1'b0, divisor_reg}) : shifted[RATIO_W-1:0];
            quo_next[l] = {quo_reg[l][DIV_W-2:0], ge};
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + SW'(1);
                if (step_reg == SW'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            divisor_reg <= divisor;
            quo_reg     <= dividend;
            rem_reg     <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[src/gefd_back.sv]
// Back end: sequencer over the serial divider, turn tracking, shaft angle
// scaling and the result register. Depends on gefd_pkg and gefd_div.
module gefd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  gefd_pkg::cmd_t   q_head,
    output logic             q_pop,
    output logic             empty,
    input  logic             pop,
    output gefd_pkg::result_t result
);
    import gefd_pkg::*;

    back_state_t          state_reg, state_next;
    cmd_t                 cmd_reg;
    logic                 div_start, div_done, out_load;
    div_word_t            div_dividend, div_quotient;

    logic [SPEED_W-1:0]   shaft_speed_reg;
    logic [ANGLE_W-1:0]   reduced_reg;
    logic [ANGLE_W-2:0]   half_reg;
    logic [ANGLE_W-1:0]   span_reg;
    logic [ANGLE_W-1:0]   shaft_angle_reg;
    logic [ANGLE_W-1:0]   prev_reduced_reg;
    logic [RATIO_W-1:0]   turn_count_reg;
    logic                 out_valid_reg;
    result_t              result_reg;

    logic signed [ANGLE_W:0]   diff, half_s;
    logic signed [RATIO_W+1:0] cnt_step, ratio_s;
    logic [RATIO_W-1:0]        cnt_new;
    logic [ANGLE_W+RATIO_W-1:0] scale_sum;

    // Dividends taken straight from the queue head at dispatch
    always_comb
    begin
        div_dividend             = '0;
        div_dividend[LANE_SPEED] = q_head.speed_mag;
        div_dividend[LANE_ANGLE] = DIV_W'(q_head.raw_angle);
        div_dividend[LANE_HALF]  = DIV_W'(HALF_SPAN);
        div_dividend[LANE_SPAN]  = DIV_W'(ENCODER_MAX);
    end

    gefd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (q_head.ratio),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_TRACK;
            end
            ST_TRACK:
                state_next = ST_SCALE;
            ST_SCALE:
                state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Wrap detection and turn count update
    always_comb
    begin
        diff     = $signed({1'b0, reduced_reg}) - $signed({1'b0, prev_reduced_reg});
        half_s   = $signed({2'b00, half_reg});
        ratio_s  = $signed({2'b00, cmd_reg.ratio});
        cnt_step = $signed({2'b00, turn_count_reg});
        if (diff > half_s)
            cnt_step = cnt_step - 10'sd1;
        else if (diff < -half_s)
            cnt_step = cnt_step + 10'sd1;
        if (cnt_step >= ratio_s)
            cnt_new = '0;
        else if (cnt_step < 10'sd0)
            cnt_new = cmd_reg.ratio - RATIO_W'(1);
        else
            cnt_new = cnt_step[RATIO_W-1:0];
    end

    // Shaft angle: turn count times span plus reduced angle
    assign scale_sum = turn_count_reg * span_reg + {{RATIO_W{1'b0}}, reduced_reg};

    // Tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_count_reg   <= '0;
            prev_reduced_reg <= '0;
        end
        else if (state_reg == ST_TRACK)
        begin
            turn_count_reg   <= cnt_new;
            prev_reduced_reg <= reduced_reg;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (div_start)
            cmd_reg <= q_head;
        if (state_reg == ST_DIV && div_done)
        begin
            shaft_speed_reg <= cmd_reg.speed_neg ?
                               (SPEED_W'(0) - div_quotient[LANE_SPEED]) :
                               div_quotient[LANE_SPEED];
            reduced_reg     <= div_quotient[LANE_ANGLE][ANGLE_W-1:0];
            half_reg        <= div_quotient[LANE_HALF][ANGLE_W-2:0];
            span_reg        <= div_quotient[LANE_SPAN][ANGLE_W-1:0];
        end
        if (state_reg == ST_SCALE)
            shaft_angle_reg <= scale_sum[ANGLE_W-1:0];
        if (out_load)
        begin
            result_reg.rotor_speed   <= cmd_reg.raw_speed;
            result_reg.shaft_speed   <= shaft_speed_reg;
            result_reg.reduced_angle <= reduced_reg;
            result_reg.turn_index    <= turn_count_reg;
            result_reg.shaft_angle   <= shaft_angle_reg;
        end
    end

    // Result register occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    assign empty  = !out_valid_reg;
    assign result = result_reg;

endmodule

[src/geared_encoder_feedback_decoder.sv]
// Top level of the geared encoder feedback decoder.
// Depends on gefd_pkg, gefd_front and gefd_back (which holds gefd_div).
//
//  Channel   Handshake            Payload
//  frame     push / full          gefd_pkg::frame_t  (raw_angle, raw_speed)
//  result    empty / pop          gefd_pkg::result_t (speeds, angles, turn index)
//  config    cfg_en               cfg_data = gear_ratio, 8 bits, ratio 0 acts as 1
//
// In the back end an item passes a dispatch step, 16 divider steps plus a done
// step in the serial divider, then track, scale and output.
// Reset empties the queue and the result register and clears the turn tracking; ratio is 1.
// The front queue holds QUEUE_DEPTH items while the back end is busy; the back
// end waits in its output step while the result register is still full.
module geared_encoder_feedback_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  gefd_pkg::frame_t             frame,
    output logic                         empty,
    input  logic                         pop,
    output gefd_pkg::result_t            result,
    input  logic                         cfg_en,
    input  logic [gefd_pkg::RATIO_W-1:0] cfg_data
);
    import gefd_pkg::*;

    logic q_pop;
    logic q_empty;
    cmd_t q_head;

    gefd_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .frame    (frame),
        .cfg_en   (cfg_en),
        .cfg_data (cfg_data),
        .q_pop    (q_pop),
        .q_empty  (q_empty),
        .q_head   (q_head)
    );

    gefd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

[src/gefd_checker.sv]
// Port-level checker for the geared encoder feedback decoder, bound to the top.
// Depends on gefd_pkg.
module gefd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              push,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input gefd_pkg::result_t result
);
    import gefd_pkg::*;

    logic [7:0] pending_reg;
    logic       in_take, out_take;

    assign in_take  = push && !full;
    assign out_take = pop && !empty;

    // Items accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else if (in_take && !out_take)
            pending_reg <= pending_reg + 8'd1;
        else if (out_take && !in_take)
            pending_reg <= pending_reg - 8'd1;
    end

    // No result without an item behind it
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> pending_reg != 8'd0)
        else $error("result shown with no item outstanding");

    // A waiting result is neither dropped nor changed
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("waiting result changed or dropped");

    // Turn index stays below the largest ratio
    a_turn_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> result.turn_index != 8'd255)
        else $error("turn index out of range");

    // For a non-negative rotor speed, the reduced speed is non-negative and never exceeds it
    a_speed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.rotor_speed >= 0 |->
            result.shaft_speed >= 0 && result.shaft_speed <= result.rotor_speed)
        else $error("shaft speed out of bound");

endmodule

bind geared_encoder_feedback_decoder gefd_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
